/* hdl/assert_macros.svh */
// assertion macros shared by the sorted key table rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define CHK_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_HOLDS(lbl, cond, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/suk_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the sorted unique key table
// no dependencies; used by the channels, controller, datapath and top level
package suk_pkg;

  localparam int KEY_W       = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 5;
  localparam int DEF_CAPACITY = 16;

  // request actions; the unused code behaves as a search
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // memory read address select
  localparam logic [1:0] RD_SCAN = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic                load_in;
    logic                idx_clear;
    logic                idx_inc;
    logic                idx_dec;
    logic                idx_load_count;
    logic                capture;
    logic                present_val;
    logic                rd_en;
    logic [1:0]          rd_sel;
    logic                wr_en;
    logic                wr_key;
    logic                count_inc;
    logic                count_dec;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic                idx_at_count;
    logic                rd_lt;
    logic                rd_eq;
    logic                idx_at_pos;
    logic                idx_last;
    logic                full;
    logic                present;
    logic [ACTION_W-1:0] action;
  } stat_t;

endpackage

/* hdl/suk_channels.sv */
`timescale 1ns / 1ps
// valid/ready channels of the sorted unique key table: request and response
// depends on suk_pkg for field widths
interface suk_req_if;
  logic                              valid;
  logic                              ready;
  logic [suk_pkg::ACTION_W-1:0]      action;
  logic signed [suk_pkg::KEY_W-1:0]  key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

interface suk_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [suk_pkg::STATUS_W-1:0] status;
  logic [suk_pkg::POS_W-1:0]    position;
  logic [suk_pkg::POS_W-1:0]    entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input position, input entry_count,
                output ready);
endinterface

/* hdl/suk_datapath.sv */
`timescale 1ns / 1ps
// datapath of the sorted unique key table: key memory, index, count, result register
// depends on suk_pkg and assert_macros.svh; driven by suk_controller
`include "assert_macros.svh"
module suk_datapath #(
  parameter int CAPACITY = suk_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  suk_pkg::cmd_t                      cmd,
  output suk_pkg::stat_t                     stat,
  input  logic [suk_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [suk_pkg::KEY_W-1:0]   in_key,
  output logic [suk_pkg::STATUS_W-1:0]       out_status,
  output logic [suk_pkg::POS_W-1:0]          out_position,
  output logic [suk_pkg::POS_W-1:0]          out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [suk_pkg::KEY_W-1:0] mem [CAPACITY];
  logic signed [suk_pkg::KEY_W-1:0] rdata;
  logic signed [suk_pkg::KEY_W-1:0] key;
  logic signed [suk_pkg::KEY_W-1:0] wdata;
  logic [suk_pkg::ACTION_W-1:0]     action;
  logic [CW-1:0]                    idx;
  logic [CW-1:0]                    idx_m1;
  logic [CW-1:0]                    idx_p1;
  logic [CW-1:0]                    pos;
  logic [CW-1:0]                    count;
  logic                             present;
  logic [AW-1:0]                    raddr;

  assign idx_m1 = idx - 1'b1;
  assign idx_p1 = idx + 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      suk_pkg::RD_PREV: raddr = idx_m1[AW-1:0];
      suk_pkg::RD_NEXT: raddr = idx_p1[AW-1:0];
      default:          raddr = idx[AW-1:0];
    endcase
  end

  assign wdata = cmd.wr_key ? key : rdata;

  // single write port at the working index, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key    <= in_key;
      action <= in_action;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_load_count) begin
      idx <= count;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1;
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
    if (cmd.capture) begin
      pos     <= idx;
      present <= cmd.present_val;
    end
    if (cmd.load_out) begin
      out_status      <= cmd.status;
      out_position    <= suk_pkg::POS_W'(pos);
      out_entry_count <= suk_pkg::POS_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + 1'b1;
    end else if (cmd.count_dec) begin
      count <= count - 1'b1;
    end
  end

  assign stat.idx_at_count = (idx == count);
  assign stat.rd_lt        = (rdata < key);
  assign stat.rd_eq        = (rdata == key);
  assign stat.idx_at_pos   = (idx == pos);
  assign stat.idx_last     = (idx_p1 >= count);
  assign stat.full         = (count == CAP_C);
  assign stat.present      = present;
  assign stat.action       = action;

  `CHK_HOLDS(dp_count_le_cap, count <= CAP_C, "entry count above capacity")
  `CHK_HOLDS(dp_wr_in_range, !cmd.wr_en || (idx < CAP_C), "write beyond table")
  `CHK_NEXT(dp_count_inc, cmd.count_inc, count == $past(count) + 1'b1, "count did not grow")
  `CHK_NEXT(dp_count_dec, cmd.count_dec, count == $past(count) - 1'b1, "count did not shrink")

endmodule

/* hdl/suk_controller.sv */
`timescale 1ns / 1ps
// controller state machine of the sorted unique key table
// depends on suk_pkg; sequences suk_datapath through scan, shift and result
module suk_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  suk_pkg::stat_t  stat,
  output suk_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_INS_RD   = 4'd4;
  localparam logic [3:0] S_INS_WR   = 4'd5;
  localparam logic [3:0] S_DEL_RD   = 4'd6;
  localparam logic [3:0] S_DEL_WR   = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [suk_pkg::STATUS_W-1:0] status;
  logic [suk_pkg::STATUS_W-1:0] status_next;
  logic                         out_free;

  // no transaction is taken while reset is held
  assign req_ready = (state == S_IDLE) && !rst;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in   = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.idx_at_count) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = suk_pkg::RD_SCAN;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.rd_lt) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          cmd.capture     = 1'b1;
          cmd.present_val = stat.rd_eq;
          state_next      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.action)
          suk_pkg::ACT_INSERT: begin
            if (stat.present) begin
              status_next = suk_pkg::ST_DUP;
              state_next  = S_FIN;
            end else if (stat.full) begin
              status_next = suk_pkg::ST_FULL;
              state_next  = S_FIN;
            end else begin
              status_next        = suk_pkg::ST_DONE;
              cmd.idx_load_count = 1'b1;
              state_next         = S_INS_RD;
            end
          end
          suk_pkg::ACT_DELETE: begin
            if (stat.present) begin
              status_next = suk_pkg::ST_DONE;
              state_next  = S_DEL_RD;
            end else begin
              status_next = suk_pkg::ST_MISSING;
              state_next  = S_FIN;
            end
          end
          default: begin
            status_next = stat.present ? suk_pkg::ST_DONE : suk_pkg::ST_MISSING;
            state_next  = S_FIN;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.idx_at_pos) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_key    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = suk_pkg::RD_PREV;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next  = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat.idx_last) begin
          cmd.count_dec = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = suk_pkg::RD_NEXT;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_DEL_RD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= suk_pkg::ST_DONE;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      status <= status_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/sorted_unique_key_table.sv */
`timescale 1ns / 1ps
// top level of the sorted unique key table: channels, controller and datapath
// depends on suk_pkg, suk_channels, suk_controller and suk_datapath
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order in a
// memory with one write port and one registered read port. Each request
// transaction (insert, delete or search; the unused action code searches)
// returns one response transaction with a status, the key's ordered position
// (the count of held keys below it, before the request) and the entry count
// after the request. Requests are handled one at a time. A request first
// scans the memory from the bottom, a read and then a compare for each key
// smaller than the request key, since every compare waits on the registered
// read. An insert then shifts the upper keys up, a read and then a write for
// each moved key, and a delete shifts them down the same way. The response
// sits in an output register, so the next request is taken while it waits;
// only a second result finding that register still full stalls. Reset
// empties the table at once through the entry count; memory contents need
// no clearing.
module sorted_unique_key_table #(
  parameter int CAPACITY = suk_pkg::DEF_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  suk_req_if.sink   req,
  suk_rsp_if.source rsp
);

  suk_pkg::cmd_t  cmd;
  suk_pkg::stat_t stat;

  // sequencing: scan, decide, shift, then load the response register
  suk_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key memory, working index, entry count and response payload
  suk_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (req.action),
    .in_key          (req.key),
    .out_status      (rsp.status),
    .out_position    (rsp.position),
    .out_entry_count (rsp.entry_count)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the sorted unique key table (sorted_unique_key_table)
// depends on suk_pkg, suk_channels and sorted_unique_key_table with the rtl below it
module testbench;

  localparam int TABLE_DEPTH = suk_pkg::DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 234;
  localparam int DIRECTED_ROWS = 26;

  // the spare action code, which the table treats as a search
  localparam logic [suk_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

  // how a directed row is checked
  localparam bit CHK_TYPED = 1'b1;
  localparam bit CHK_PRED = 1'b0;

  typedef struct packed {
    logic [suk_pkg::STATUS_W-1:0] status;
    logic [suk_pkg::POS_W-1:0]    position;
    logic [suk_pkg::POS_W-1:0]    entry_count;
  } table_reply_t;

  typedef struct packed {
    logic [suk_pkg::ACTION_W-1:0] action;
    logic [suk_pkg::KEY_W-1:0]    key;
    bit                           check;
    table_reply_t                 reply;
  } script_row_t;

  logic clk;
  logic rst;

  suk_req_if req_ch ();
  suk_rsp_if rsp_ch ();

  sorted_unique_key_table #(.CAPACITY(TABLE_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the table, kept in ascending signed order
  logic signed [suk_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int                               shadow_count;

  // replies still owed by the table, oldest first
  table_reply_t pending_replies [$];

  // candidate keys for the random part, so inserts, deletes and hits meet
  logic [suk_pkg::KEY_W-1:0] key_pool [$];

  int send_idle_pct;
  int rsp_stall_pct;
  int fail_count;
  int cycle_count;

  // directed rows: empty table, both key extremes, duplicate, spare action,
  // a fill up to capacity, refused insert at full, duplicate at full, and
  // deletes of both extremes from a full table
  script_row_t script [DIRECTED_ROWS] = '{
    '{suk_pkg::ACT_SEARCH, 32'h0000_0000, CHK_TYPED, '{suk_pkg::ST_MISSING, 5'd0, 5'd0}},
    '{suk_pkg::ACT_DELETE, 32'hFFFF_FFFF, CHK_TYPED, '{suk_pkg::ST_MISSING, 5'd0, 5'd0}},
    '{suk_pkg::ACT_INSERT, 32'h7FFF_FFFF, CHK_TYPED, '{suk_pkg::ST_DONE, 5'd0, 5'd1}},
    '{suk_pkg::ACT_INSERT, 32'h8000_0000, CHK_TYPED, '{suk_pkg::ST_DONE, 5'd0, 5'd2}},
    '{suk_pkg::ACT_INSERT, 32'h7FFF_FFFF, CHK_TYPED, '{suk_pkg::ST_DUP, 5'd1, 5'd2}},
    '{ACT_SPARE,           32'h8000_0000, CHK_TYPED, '{suk_pkg::ST_DONE, 5'd0, 5'd2}},
    '{suk_pkg::ACT_SEARCH, 32'h0000_0000, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'hFFFF_FFFF, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0000, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0001, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h4000_0000, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'hC000_0000, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h7FFF_FFFE, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h8000_0001, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h5555_5555, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'hAAAA_AAAA, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0002, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'hFFFF_FFFE, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0064, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'hFFFF_FF9C, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h1234_5678, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0003, CHK_PRED,  '0},
    '{suk_pkg::ACT_INSERT, 32'h0000_0000, CHK_PRED,  '0},
    '{suk_pkg::ACT_SEARCH, 32'h5555_5555, CHK_PRED,  '0},
    '{suk_pkg::ACT_DELETE, 32'h8000_0000, CHK_TYPED, '{suk_pkg::ST_DONE, 5'd0, 5'd15}},
    '{suk_pkg::ACT_DELETE, 32'h7FFF_FFFF, CHK_TYPED, '{suk_pkg::ST_DONE, 5'd14, 5'd14}}
  };

  // free-running clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // applies one request to the shadow table and returns the reply it earns;
  // position is the count of held keys below the key, taken before the change
  function automatic table_reply_t table_outcome(
      input logic [suk_pkg::ACTION_W-1:0] act,
      input logic signed [suk_pkg::KEY_W-1:0] k);
    int           rank;
    bit           hit;
    table_reply_t r;
    rank = 0;
    while (rank < shadow_count && shadow_keys[rank] < k) rank++;
    hit = (rank < shadow_count) && (shadow_keys[rank] == k);
    case (act)
      suk_pkg::ACT_INSERT: begin
        if (hit) begin
          r.status = suk_pkg::ST_DUP;
        end else if (shadow_count >= TABLE_DEPTH) begin
          // new key with no room left: table untouched
          r.status = suk_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > rank; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[rank] = k;
          shadow_count++;
          r.status = suk_pkg::ST_DONE;
        end
      end
      suk_pkg::ACT_DELETE: begin
        if (hit) begin
          for (int i = rank; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          r.status = suk_pkg::ST_DONE;
        end else begin
          r.status = suk_pkg::ST_MISSING;
        end
      end
      // search, and the spare code that behaves as one
      default: r.status = hit ? suk_pkg::ST_DONE : suk_pkg::ST_MISSING;
    endcase
    r.position = rank[suk_pkg::POS_W-1:0];
    r.entry_count = shadow_count[suk_pkg::POS_W-1:0];
    return r;
  endfunction

  // drives one request transaction with random idle cycles ahead of it; on
  // acceptance the shadow table is updated and the reply is queued, either
  // the typed one or the predicted one
  task automatic send_request(input logic [suk_pkg::ACTION_W-1:0] act,
                              input logic [suk_pkg::KEY_W-1:0] k,
                              input bit typed, input table_reply_t typed_reply);
    table_reply_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = table_outcome(act, k);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // one random request: inserts and lookups mostly hit a shared key pool,
  // with the insert share swinging between fill and drain every 48 items so
  // the table keeps passing through empty and full
  task automatic send_random(input int item_no);
    int                           insert_pct;
    int                           pick;
    logic [suk_pkg::ACTION_W-1:0] act;
    logic [suk_pkg::KEY_W-1:0]    k;
    insert_pct = ((item_no / 48) % 2 == 0) ? 70 : 25;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) act = suk_pkg::ACT_INSERT;
    else if (pick < insert_pct + (100 - insert_pct) * 6 / 10) act = suk_pkg::ACT_DELETE;
    else if (pick < 96) act = suk_pkg::ACT_SEARCH;
    else act = ACT_SPARE;
    // free keys are noise, mostly misses; the rare insert of one joins the pool
    if ($urandom_range(0, 99) < ((act == suk_pkg::ACT_INSERT) ? 2 : 10)) begin
      k = $urandom;
      if (act == suk_pkg::ACT_INSERT) key_pool.push_back(k);
    end else begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    send_request(act, k, CHK_PRED, '0);
  endtask

  // response side: random back-pressure, and every accepted transaction is
  // compared field by field with the oldest queued reply
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected response, status %0d position %0d count %0d", $time,
                   rsp_ch.status, rsp_ch.position, rsp_ch.entry_count);
          fail_count++;
        end else begin
          table_reply_t want;
          want = pending_replies.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                     want.position, rsp_ch.position);
            fail_count++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, actual %0d", $time,
                     want.entry_count, rsp_ch.entry_count);
            fail_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int item_no;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = suk_pkg::ACT_SEARCH;
    req_ch.key = '0;
    shadow_count = 0;
    send_idle_pct = 20;
    rsp_stall_pct = 47;
    item_no = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (script[i]) begin
      send_request(script[i].action, script[i].key, script[i].check, script[i].reply);
    end

    // key pool: both extremes, zero, minus one, whatever the table holds now,
    // then random fill
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7FFF_FFFF);
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    for (int i = 0; i < shadow_count; i++) key_pool.push_back(shadow_keys[i]);
    while (key_pool.size() < 28) key_pool.push_back($urandom);

    // random part in three idling phases: sender light and receiver heavy,
    // then swapped, then no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 47 : 0;
      rsp_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 20 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_random(item_no);
        item_no++;
      end
    end
    req_ch.valid <= 1'b0;

    // drain, then give a stray response time to show up
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
